@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame parser checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/gsfp_pkg.sv @@
// ---------------------------------------------------------------------------
// gsfp_pkg
// Types and constants of the gas sensor frame parser.
// ---------------------------------------------------------------------------
package gsfp_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HEADER   = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    LVL_NORMAL  = 2'd0,
    LVL_WARNING = 2'd1,
    LVL_DANGER  = 2'd2
  } level_t;

  localparam logic [1:0] REG_DANGER  = 2'd0;
  localparam logic [1:0] REG_WARNING = 2'd1;
  localparam logic [1:0] REG_ALARM   = 2'd2;

  localparam logic [15:0] DANGER_RESET  = 16'd200;
  localparam logic [15:0] WARNING_RESET = 16'd50;
  localparam logic [7:0]  ALARM_RESET   = 8'd3;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] HDR_BYTE1  = 8'h18;
  localparam logic [7:0] HDR_BYTE2  = 8'h04;
  localparam logic [3:0] LAST_POS   = 4'd8;
  localparam logic [3:0] POS_HDR1   = 4'd1;
  localparam logic [3:0] POS_HDR2   = 4'd2;
  localparam logic [3:0] POS_PPM_HI = 4'd4;
  localparam logic [3:0] POS_PPM_LO = 4'd5;

  localparam logic [7:0] MISS_MAX = 8'hFF;

  // Frame event from the byte tracker.
  typedef struct packed {
    logic         done;
    status_t      status;
    logic [15:0]  ppm;
  } frame_evt_t;

endpackage

@@ design/gsfp_frame_tracker.sv @@
// ---------------------------------------------------------------------------
// gsfp_frame_tracker
// Start-byte hunt, header check, running checksum, ppm capture and timeout events.
// ---------------------------------------------------------------------------
module gsfp_frame_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 func,
  input  logic [7:0]           rx_byte,
  output gsfp_pkg::frame_evt_t evt
);

  logic [3:0] pos, pos_next;
  logic [7:0] sum, sum_next;
  logic       hdr_good, hdr_good_next;
  logic [7:0] ppm_high, ppm_high_next;
  logic [7:0] ppm_low, ppm_low_next;
  logic       hunting;

  assign hunting = (pos == 4'd0) || (pos > gsfp_pkg::LAST_POS);

  always_comb begin
    pos_next      = pos;
    sum_next      = sum;
    hdr_good_next = hdr_good;
    ppm_high_next = ppm_high;
    ppm_low_next  = ppm_low;
    evt.done      = 1'b0;
    evt.status    = gsfp_pkg::ST_OK;
    evt.ppm       = {ppm_high, ppm_low};
    if (accept) begin
      priority if (func) begin
        pos_next   = 4'd0;
        evt.done   = 1'b1;
        evt.status = gsfp_pkg::ST_TIMEOUT;
      end else if (hunting) begin
        if (rx_byte == gsfp_pkg::START_BYTE) begin
          sum_next      = gsfp_pkg::START_BYTE;
          hdr_good_next = 1'b1;
          pos_next      = 4'd1;
        end else begin
          pos_next = 4'd0;
        end
      end else if (pos == gsfp_pkg::LAST_POS) begin
        pos_next = 4'd0;
        evt.done = 1'b1;
        priority if (!hdr_good) begin
          evt.status = gsfp_pkg::ST_HEADER;
        end else if (~sum != rx_byte) begin
          evt.status = gsfp_pkg::ST_CHECKSUM;
        end else begin
          evt.status = gsfp_pkg::ST_OK;
        end
      end else begin
        if (pos == gsfp_pkg::POS_HDR1 && rx_byte != gsfp_pkg::HDR_BYTE1) begin
          hdr_good_next = 1'b0;
        end
        if (pos == gsfp_pkg::POS_HDR2 && rx_byte != gsfp_pkg::HDR_BYTE2) begin
          hdr_good_next = 1'b0;
        end
        if (pos == gsfp_pkg::POS_PPM_HI) begin
          ppm_high_next = rx_byte;
        end
        if (pos == gsfp_pkg::POS_PPM_LO) begin
          ppm_low_next = rx_byte;
        end
        sum_next = sum + rx_byte;
        pos_next = pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 4'd0;
      sum      <= 8'd0;
      hdr_good <= 1'b1;
      ppm_high <= 8'd0;
      ppm_low  <= 8'd0;
    end else begin
      pos      <= pos_next;
      sum      <= sum_next;
      hdr_good <= hdr_good_next;
      ppm_high <= ppm_high_next;
      ppm_low  <= ppm_low_next;
    end
  end

endmodule

@@ design/gas_sensor_frame_parser_unit.sv @@
// ---------------------------------------------------------------------------
// gas_sensor_frame_parser_unit
// Nine-byte CO sensor frame parser with level classing and miss alarm.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transaction: tdata = received byte, tuser = 1
//   for a read-window timeout (tdata ignored), 0 for a byte.
//   m_axis carries one result per finished frame or timeout; tuser holds the
//   status code, tdata the ppm, level, miss count and alarm flag.
//   cfg_we/cfg_addr/cfg_data write the danger threshold (0), warning
//   threshold (1) and miss alarm count (2); write only while idle.
// Timing:
//   A result appears on m_axis in the cycle after the byte that ends the frame
//   (or the timeout) is accepted. One item is taken every cycle unless a result
//   is stalled on m_axis; the single output register sets the rate.
// Reset:
//   rst clears the frame tracker to hunting, the miss counter to zero, the
//   registers to 200/50/3 and drops any pending result.
// Stall:
//   While a result waits with m_axis_tready low, s_axis_tready is low; the
//   result is held stable until taken.
// ---------------------------------------------------------------------------
module gas_sensor_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] co_ppm, [17:16] level,
                                      // [25:18] misses, [26] miss_alarm
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  logic [15:0] danger_thr;
  logic [15:0] warning_thr;
  logic [7:0]  alarm_cnt;

  logic                 accept;
  gsfp_pkg::frame_evt_t evt;

  logic [7:0]  misses, misses_next;
  logic [15:0] ppm_res;
  gsfp_pkg::level_t level_res;

  logic              out_valid;
  gsfp_pkg::status_t out_status;
  logic [15:0]       out_ppm;
  gsfp_pkg::level_t  out_level;
  logic [7:0]        out_misses;
  logic              out_alarm;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  gsfp_frame_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .func    (s_axis_tuser),
    .rx_byte (s_axis_tdata),
    .evt     (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      danger_thr  <= gsfp_pkg::DANGER_RESET;
      warning_thr <= gsfp_pkg::WARNING_RESET;
      alarm_cnt   <= gsfp_pkg::ALARM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gsfp_pkg::REG_DANGER:  danger_thr  <= cfg_data;
        gsfp_pkg::REG_WARNING: warning_thr <= cfg_data;
        gsfp_pkg::REG_ALARM:   alarm_cnt   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    misses_next = misses;
    ppm_res     = 16'd0;
    level_res   = gsfp_pkg::LVL_NORMAL;
    if (evt.status == gsfp_pkg::ST_OK) begin
      misses_next = 8'd0;
      ppm_res     = evt.ppm;
      priority if (evt.ppm > danger_thr) begin
        level_res = gsfp_pkg::LVL_DANGER;
      end else if (evt.ppm > warning_thr) begin
        level_res = gsfp_pkg::LVL_WARNING;
      end else begin
        level_res = gsfp_pkg::LVL_NORMAL;
      end
    end else if (misses != gsfp_pkg::MISS_MAX) begin
      misses_next = misses + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      misses    <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (evt.done) begin
        misses    <= misses_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.done) begin
      out_status <= evt.status;
      out_ppm    <= ppm_res;
      out_level  <= level_res;
      out_misses <= misses_next;
      out_alarm  <= (misses_next >= alarm_cnt);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {5'd0, out_alarm, out_misses, out_level, out_ppm};

endmodule

@@ design/gsfp_checker.sv @@
// ---------------------------------------------------------------------------
// gsfp_checker
// Port-level checks of the frame parser result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic        stall;
  logic        ok_out;
  logic        bad_out;
  logic [33:0] m_word;
  logic [7:0]  res_misses;

  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign ok_out     = m_axis_tvalid && (m_axis_tuser == gsfp_pkg::ST_OK);
  assign bad_out    = m_axis_tvalid && (m_axis_tuser != gsfp_pkg::ST_OK);
  assign m_word     = {m_axis_tuser, m_axis_tdata};
  assign res_misses = m_axis_tdata[25:18];

  `ASSERT_NEXT(a_hold, clk, rst, stall, m_axis_tvalid && $stable(m_word))
  `ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !m_axis_tvalid)
  `ASSERT_IMPL(a_ok_clears, clk, rst, ok_out, res_misses == 8'd0)
  `ASSERT_IMPL(a_bad_zero, clk, rst, bad_out, m_axis_tdata[17:0] == 18'd0 && res_misses != 8'd0)
  `ASSERT_IMPL(a_ready, clk, rst, stall, !s_axis_tready)

endmodule

bind gas_sensor_frame_parser_unit gsfp_checker u_gsfp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
